// ===== rtl/core/pfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared constants for the paletted framebuffer engine: frame geometry,
// command codes and the built-in RGB565 palette.
// ----------------------------------------------------------------------------
package pfe_pkg;

  localparam int unsigned WIDTH        = 240;
  localparam int unsigned HEIGHT       = 240;
  localparam int unsigned FRAME_PIXELS = WIDTH * HEIGHT;

  localparam int unsigned ADDR_W = $clog2(FRAME_PIXELS);
  localparam int unsigned COL_W  = $clog2(WIDTH + 1);
  localparam int unsigned ROW_W  = $clog2(HEIGHT + 1);
  localparam int unsigned CLIP_W = 18;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_SET   = 3'd1;
  localparam logic [2:0] CMD_GET   = 3'd2;
  localparam logic [2:0] CMD_FILL  = 3'd3;
  localparam logic [2:0] CMD_SCAN  = 3'd4;

  // 16 named colors, 6x6x6 cube, 24-step grey ramp
  localparam logic [15:0] PALETTE [256] = '{
    16'h0000, 16'hFFFF, 16'h8800, 16'h0639, 16'hC897, 16'h04A8, 16'h0015, 16'hEEE7,
    16'hDD86, 16'h6222, 16'hFB2C, 16'h4228, 16'h8C51, 16'h8FF1, 16'h777F, 16'hBDD7,
    16'h0000, 16'h0006, 16'h000C, 16'h0013, 16'h0019, 16'h001F, 16'h01A0, 16'h01A6,
    16'h01AC, 16'h01B3, 16'h01B9, 16'h01BF, 16'h0320, 16'h0326, 16'h032C, 16'h0333,
    16'h0339, 16'h033F, 16'h04C0, 16'h04C6, 16'h04CC, 16'h04D3, 16'h04D9, 16'h04DF,
    16'h0640, 16'h0646, 16'h064C, 16'h0653, 16'h0659, 16'h065F, 16'h07E0, 16'h07E6,
    16'h07EC, 16'h07F3, 16'h07F9, 16'h07FF, 16'h3000, 16'h3006, 16'h300C, 16'h3013,
    16'h3019, 16'h301F, 16'h31A0, 16'h31A6, 16'h31AC, 16'h31B3, 16'h31B9, 16'h31BF,
    16'h3320, 16'h3326, 16'h332C, 16'h3333, 16'h3339, 16'h333F, 16'h34C0, 16'h34C6,
    16'h34CC, 16'h34D3, 16'h34D9, 16'h34DF, 16'h3640, 16'h3646, 16'h364C, 16'h3653,
    16'h3659, 16'h365F, 16'h37E0, 16'h37E6, 16'h37EC, 16'h37F3, 16'h37F9, 16'h37FF,
    16'h6000, 16'h6006, 16'h600C, 16'h6013, 16'h6019, 16'h601F, 16'h61A0, 16'h61A6,
    16'h61AC, 16'h61B3, 16'h61B9, 16'h61BF, 16'h6320, 16'h6326, 16'h632C, 16'h6333,
    16'h6339, 16'h633F, 16'h64C0, 16'h64C6, 16'h64CC, 16'h64D3, 16'h64D9, 16'h64DF,
    16'h6640, 16'h6646, 16'h664C, 16'h6653, 16'h6659, 16'h665F, 16'h67E0, 16'h67E6,
    16'h67EC, 16'h67F3, 16'h67F9, 16'h67FF, 16'h9800, 16'h9806, 16'h980C, 16'h9813,
    16'h9819, 16'h981F, 16'h99A0, 16'h99A6, 16'h99AC, 16'h99B3, 16'h99B9, 16'h99BF,
    16'h9B20, 16'h9B26, 16'h9B2C, 16'h9B33, 16'h9B39, 16'h9B3F, 16'h9CC0, 16'h9CC6,
    16'h9CCC, 16'h9CD3, 16'h9CD9, 16'h9CDF, 16'h9E40, 16'h9E46, 16'h9E4C, 16'h9E53,
    16'h9E59, 16'h9E5F, 16'h9FE0, 16'h9FE6, 16'h9FEC, 16'h9FF3, 16'h9FF9, 16'h9FFF,
    16'hC800, 16'hC806, 16'hC80C, 16'hC813, 16'hC819, 16'hC81F, 16'hC9A0, 16'hC9A6,
    16'hC9AC, 16'hC9B3, 16'hC9B9, 16'hC9BF, 16'hCB20, 16'hCB26, 16'hCB2C, 16'hCB33,
    16'hCB39, 16'hCB3F, 16'hCCC0, 16'hCCC6, 16'hCCCC, 16'hCCD3, 16'hCCD9, 16'hCCDF,
    16'hCE40, 16'hCE46, 16'hCE4C, 16'hCE53, 16'hCE59, 16'hCE5F, 16'hCFE0, 16'hCFE6,
    16'hCFEC, 16'hCFF3, 16'hCFF9, 16'hCFFF, 16'hF800, 16'hF806, 16'hF80C, 16'hF813,
    16'hF819, 16'hF81F, 16'hF9A0, 16'hF9A6, 16'hF9AC, 16'hF9B3, 16'hF9B9, 16'hF9BF,
    16'hFB20, 16'hFB26, 16'hFB2C, 16'hFB33, 16'hFB39, 16'hFB3F, 16'hFCC0, 16'hFCC6,
    16'hFCCC, 16'hFCD3, 16'hFCD9, 16'hFCDF, 16'hFE40, 16'hFE46, 16'hFE4C, 16'hFE53,
    16'hFE59, 16'hFE5F, 16'hFFE0, 16'hFFE6, 16'hFFEC, 16'hFFF3, 16'hFFF9, 16'hFFFF,
    16'h0000, 16'h0861, 16'h18A3, 16'h2104, 16'h2965, 16'h39C7, 16'h4228, 16'h4A69,
    16'h5ACB, 16'h632C, 16'h6B6D, 16'h7BCF, 16'h8430, 16'h9492, 16'h9CD3, 16'hA534,
    16'hB596, 16'hBDD7, 16'hC638, 16'hD69A, 16'hDEFB, 16'hE75C, 16'hF79E, 16'hFFFF
  };

endpackage

// ===== rtl/core/paletted_framebuffer_engine_top.sv =====
// ----------------------------------------------------------------------------
// paletted_framebuffer_engine_top
// 8-bit indexed framebuffer with clipped pixel access, rectangle fill, clear
// and RGB565 raster scan-out through the built-in palette.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | flow
//  ----------+-------------------------------------------+-----------------------
//  request   | start, busy, cmd_i, x_pos_i, y_pos_i,     | taken when start && !busy
//            | rect_width_i, rect_height_i, pixel_color_i|
//  result    | out_strobe_o, out_byte_o, last_o,         | one cycle per strobe,
//            | frame_end_o                               | no backpressure
//
// Cycles: set 2, get 3 (result strobed 3 cycles after the request), scan 4
// (high byte 3 cycles after the request, low byte one cycle later), clear
// WIDTH*HEIGHT + 1, fill 3 + one per clipped pixel. One write port on the
// pixel memory and one row/column step unit set the clear and fill rates.
// Reset clears the sequencer and scan pointer; the pixel memory is not reset.
// Results cannot be stalled; busy holds off requests while a command runs.
module paletted_framebuffer_engine_top
  import pfe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd_i,
  input  logic signed [15:0] x_pos_i,
  input  logic signed [15:0] y_pos_i,
  input  logic signed [15:0] rect_width_i,
  input  logic signed [15:0] rect_height_i,
  input  logic [7:0]         pixel_color_i,
  output logic               out_strobe_o,
  output logic [7:0]         out_byte_o,
  output logic               last_o,
  output logic               frame_end_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_ADDR, S_GRESP, S_FSETUP, S_FCHK, S_FILL,
    S_SREAD, S_SPAL, S_SLO
  } state_e;

  state_e                    state_q;
  logic [2:0]                cmd_q;
  logic signed [15:0]        x_q, y_q, w_q, h_q;
  logic [7:0]                color_q;
  logic                      onscreen_q;
  logic [ADDR_W-1:0]         cnt_q;
  logic [ADDR_W-1:0]         scan_ptr_q;
  logic signed [CLIP_W-1:0]  x0_q, x1_q, y0_q, y1_q;
  logic [COL_W-1:0]          col_q, col_start_q, col_end_q;
  logic [ROW_W-1:0]          row_q, row_end_q;
  logic [ADDR_W-1:0]         row_base_q;
  logic [7:0]                lo_byte_q;
  logic                      strobe_q, last_q, fend_q;
  logic [7:0]                obyte_q;

  logic [7:0]                mem_q [FRAME_PIXELS];
  logic [7:0]                rd_data_q;

  logic                      onscreen;
  logic [ADDR_W-1:0]         pix_addr;
  logic                      mem_we;
  logic [ADDR_W-1:0]         mem_waddr, mem_raddr;
  logic [7:0]                mem_wdata;
  logic signed [CLIP_W-1:0]  sx, sy, x_end, y_end;
  logic [15:0]               rgb;

  assign onscreen = !x_q[15] && !y_q[15] &&
                    (x_q < 16'(WIDTH)) && (y_q < 16'(HEIGHT));
  assign pix_addr = ADDR_W'(ADDR_W'(y_q[ROW_W-1:0]) * ADDR_W'(WIDTH)
                    + ADDR_W'(x_q[COL_W-1:0]));

  assign sx    = CLIP_W'(x_q);
  assign sy    = CLIP_W'(y_q);
  assign x_end = sx + CLIP_W'(w_q);
  assign y_end = sy + CLIP_W'(h_q);

  assign rgb = PALETTE[rd_data_q];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pix_addr;
    mem_wdata = color_q;
    mem_raddr = pix_addr;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
      end
      S_ADDR: begin
        mem_we = (cmd_q == CMD_SET) && onscreen;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(row_base_q + ADDR_W'(col_q));
      end
      S_SREAD: begin
        mem_raddr = scan_ptr_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      scan_ptr_q <= '0;
      strobe_q   <= 1'b0;
      last_q     <= 1'b0;
      fend_q     <= 1'b0;
      obyte_q    <= '0;
    end else begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      fend_q   <= 1'b0;
      obyte_q  <= '0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            cmd_q   <= cmd_i;
            x_q     <= x_pos_i;
            y_q     <= y_pos_i;
            w_q     <= rect_width_i;
            h_q     <= rect_height_i;
            color_q <= pixel_color_i;
            cnt_q   <= '0;
            case (cmd_i)
              CMD_CLEAR:        state_q <= S_CLEAR;
              CMD_SET, CMD_GET: state_q <= S_ADDR;
              CMD_FILL:         state_q <= S_FSETUP;
              CMD_SCAN:         state_q <= S_SREAD;
              default:          state_q <= S_IDLE;
            endcase
          end
        end
        S_CLEAR: begin
          cnt_q <= ADDR_W'(cnt_q + 1'b1);
          if (cnt_q == ADDR_W'(FRAME_PIXELS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_ADDR: begin
          onscreen_q <= onscreen;
          state_q    <= (cmd_q == CMD_GET) ? S_GRESP : S_IDLE;
        end
        S_GRESP: begin
          strobe_q <= 1'b1;
          last_q   <= 1'b1;
          obyte_q  <= onscreen_q ? rd_data_q : 8'h00;
          state_q  <= S_IDLE;
        end
        S_FSETUP: begin
          x0_q    <= sx[CLIP_W-1] ? '0 : sx;
          y0_q    <= sy[CLIP_W-1] ? '0 : sy;
          x1_q    <= (x_end > $signed(CLIP_W'(WIDTH))) ? $signed(CLIP_W'(WIDTH)) : x_end;
          y1_q    <= (y_end > $signed(CLIP_W'(HEIGHT))) ? $signed(CLIP_W'(HEIGHT)) : y_end;
          state_q <= S_FCHK;
        end
        S_FCHK: begin
          col_start_q <= x0_q[COL_W-1:0];
          col_q       <= x0_q[COL_W-1:0];
          col_end_q   <= x1_q[COL_W-1:0];
          row_q       <= y0_q[ROW_W-1:0];
          row_end_q   <= y1_q[ROW_W-1:0];
          row_base_q  <= ADDR_W'(ADDR_W'(y0_q[ROW_W-1:0]) * ADDR_W'(WIDTH));
          state_q     <= ((x0_q >= x1_q) || (y0_q >= y1_q)) ? S_IDLE : S_FILL;
        end
        S_FILL: begin
          if (COL_W'(col_q + 1'b1) == col_end_q) begin
            col_q      <= col_start_q;
            row_q      <= ROW_W'(row_q + 1'b1);
            row_base_q <= ADDR_W'(row_base_q + ADDR_W'(WIDTH));
            if (ROW_W'(row_q + 1'b1) == row_end_q) begin
              state_q <= S_IDLE;
            end
          end else begin
            col_q <= COL_W'(col_q + 1'b1);
          end
        end
        S_SREAD: begin
          state_q <= S_SPAL;
        end
        S_SPAL: begin
          strobe_q  <= 1'b1;
          obyte_q   <= rgb[15:8];
          lo_byte_q <= rgb[7:0];
          state_q   <= S_SLO;
        end
        S_SLO: begin
          strobe_q <= 1'b1;
          last_q   <= 1'b1;
          obyte_q  <= lo_byte_q;
          if (scan_ptr_q == ADDR_W'(FRAME_PIXELS - 1)) begin
            fend_q     <= 1'b1;
            scan_ptr_q <= '0;
          end else begin
            scan_ptr_q <= ADDR_W'(scan_ptr_q + 1'b1);
          end
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign out_strobe_o = strobe_q;
  assign out_byte_o   = obyte_q;
  assign last_o       = last_q;
  assign frame_end_o  = fend_q;

endmodule

// ===== rtl/core/pfe_checker.sv =====
// ----------------------------------------------------------------------------
// pfe_checker
// Port-level checks on result sequencing and command latency of the
// framebuffer engine, bound to the top level.
// ----------------------------------------------------------------------------
module pfe_checker
  import pfe_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [2:0] cmd_i,
  input logic       out_strobe_o,
  input logic       last_o,
  input logic       frame_end_o
);

  a_fend_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end_o |-> (out_strobe_o && last_o))
    else $error("frame_end without final result");

  a_hi_then_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !last_o) |=> (out_strobe_o && last_o))
    else $error("scan high byte not followed by low byte");

  a_get_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_GET) |->
      ##3 (out_strobe_o && last_o && !frame_end_o))
    else $error("get result missing");

  a_scan_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && cmd_i == CMD_SCAN) |->
      ##3 (out_strobe_o && !last_o) ##1 (out_strobe_o && last_o))
    else $error("scan results missing");

endmodule

bind paletted_framebuffer_engine_top pfe_checker u_pfe_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .cmd_i        (cmd_i),
  .out_strobe_o (out_strobe_o),
  .last_o       (last_o),
  .frame_end_o  (frame_end_o)
);
